>>> hdl/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
`default_nettype none
package upd_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int MaxRes = 3;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_PCT  = 3'b010,
        MODE_HEX1 = 3'b100
    } t_mode;

    typedef logic [1:0] t_cnt;

    // One group holds every output byte caused by one input word.
    typedef struct packed {
        t_cnt                   cnt;
        logic                   last;
        logic [MaxRes-1:0][7:0] bytes;
    } t_group;

    function automatic logic is_hex(logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // Only meaningful for characters accepted by is_hex.
    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/url_percent_decoder_unit.sv
// Top level of the streaming URL percent decoder with '+' read as a space.
//
//  channel   handshake          payload
//  input     push / full        i_in_byte[7:0], i_in_last
//  result    empty / pop        o_out_byte[7:0], o_run_end, o_stream_end
//
// One word is taken each cycle while the group queue has room; the back end
// emits one byte per cycle while the result side keeps popping, so the queue
// depth sets how long a burst of three-byte groups can be absorbed. The first
// byte of a word passes the group queue and then the output register before it
// is on the result ports. Synchronous reset empties the queue and the output
// register and returns the escape state to idle. Either side may stall alone.
`default_nettype none
module url_percent_decoder_unit
    import upd_pkg::*;
#(
    parameter int QDEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_run_end,
    output logic            o_stream_end
);

    logic   accept;
    logic   q_push, q_pop, q_valid, q_full;
    t_group q_in, q_head;
    logic   out_valid;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    upd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_q_push  (q_push),
        .o_q_group (q_in)
    );

    upd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    upd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (q_valid),
        .o_head_pop   (q_pop),
        .i_pop        (pop),
        .o_valid      (out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end)
    );

endmodule
`default_nettype wire

>>> hdl/upd_front.sv
// Front end: escape state machine that turns each input word into a group of output bytes.
`default_nettype none
module upd_front
    import upd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic   i_in_last,
    output logic        o_q_push,
    output t_group      o_q_group
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_pending, n_pending;

    logic       hv;
    logic       hold;
    logic       decoded;
    logic       plain_opens;
    logic [7:0] plain_byte;
    t_cnt       pre_cnt;
    t_cnt       cnt;

    always_comb begin
        hv          = is_hex(i_in_byte);
        hold        = 1'b0;
        decoded     = 1'b0;
        pre_cnt     = 2'd0;
        n_pending   = r_pending;
        plain_opens = (i_in_byte == CH_PCT) && !i_in_last;
        plain_byte  = (i_in_byte == CH_PLUS) ? CH_SPACE : i_in_byte;

        case (r_mode)
            MODE_PCT: begin
                if (hv && !i_in_last) begin
                    hold      = 1'b1;
                    n_pending = i_in_byte;
                end else begin
                    pre_cnt = 2'd1;
                end
            end
            MODE_HEX1: begin
                if (hv && is_hex(r_pending)) begin
                    decoded = 1'b1;
                end else begin
                    pre_cnt = 2'd2;
                end
            end
            default: begin
                pre_cnt = 2'd0;
            end
        endcase

        o_q_group.last     = i_in_last;
        o_q_group.bytes[0] = (pre_cnt == 2'd0) ? plain_byte : CH_PCT;
        o_q_group.bytes[1] = (pre_cnt == 2'd1) ? plain_byte : r_pending;
        o_q_group.bytes[2] = plain_byte;
        if (decoded) begin
            o_q_group.bytes[0] = {hex_val(r_pending), hex_val(i_in_byte)};
            cnt = 2'd1;
        end else if (hold) begin
            cnt = 2'd0;
        end else begin
            cnt = pre_cnt + t_cnt'(!plain_opens);
        end
        o_q_group.cnt = cnt;
        o_q_push      = i_accept && (cnt != 2'd0);

        if (i_in_last) begin
            n_mode = MODE_IDLE;
        end else if (hold) begin
            n_mode = MODE_HEX1;
        end else if (!decoded && plain_opens) begin
            n_mode = MODE_PCT;
        end else begin
            n_mode = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_pending <= 8'h00;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
        end
    end

    // A held first digit is always a hex character.
    a_pending_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HEX1 |-> is_hex(r_pending))
        else $error("escape holds a non-hex digit");

    // The final word of a string always leaves a group and returns to idle.
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_in_last |-> o_q_push)
        else $error("final word produced no output");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_in_last |=> r_mode == MODE_IDLE)
        else $error("escape state survived the end of a string");

endmodule
`default_nettype wire

>>> hdl/upd_queue.sv
// Short register queue of output groups between the front end and the back end.
`default_nettype none
module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_group    i_group,
    input  wire logic i_pop,
    output t_group    o_head,
    output logic      o_valid,
    output logic      o_full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_group            r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntW-1:0]   r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
        logic [PtrW-1:0] q;
        if (p == PtrW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

    // The front end only offers a group when the queue has room.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("group offered to a full queue");

endmodule
`default_nettype wire

>>> hdl/upd_back.sv
// Back end: serialises queued groups into single bytes behind an output register.
`default_nettype none
module upd_back
    import upd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_group     i_head,
    input  wire logic  i_head_valid,
    output logic       o_head_pop,
    input  wire logic  i_pop,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_stream_end
);

    t_cnt       r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_end, r_stream_end;

    logic take;
    logic at_end;

    assign take       = i_head_valid && (!r_valid || i_pop);
    assign at_end     = (r_idx == t_cnt'(i_head.cnt - 2'd1));
    assign o_head_pop = take && at_end;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte       <= i_head.bytes[r_idx];
            r_run_end    <= at_end;
            r_stream_end <= at_end && i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_end    = r_run_end;
    assign o_stream_end = r_stream_end;

    // Empty groups never enter the queue, and the byte index stays inside the group.
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (i_head.cnt != 2'd0) && (r_idx < i_head.cnt))
        else $error("byte index outside the queued group");

    a_stream_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_stream_end |-> r_run_end)
        else $error("string end without run end");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> r_idx == 2'd0)
        else $error("partial group with empty queue");

endmodule
`default_nettype wire

>>> sim/tb_url_percent_decoder_unit.sv
// Self-checking testbench for the streaming URL percent decoder.
module tb_url_percent_decoder_unit;
    import upd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 430;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } t_dec_byte;

    // Returns the nibble value of a hex character, or -1 for any other byte.
    function automatic int hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return int'(c - 8'h30);
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            return int'(c - 8'h61) + 10;
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            return int'(c - 8'h41) + 10;
        end
        return -1;
    endfunction

    class decode_scoreboard;
        t_mode      mode;
        logic [7:0] held_digit;
        t_dec_byte  pending_out[$];
        t_dec_byte  group[$];
        int         errors;
        int         words_in;
        int         bytes_out;
        int         strings_done;

        function new();
            mode = MODE_IDLE;
            held_digit = 8'h00;
            errors = 0;
            words_in = 0;
            bytes_out = 0;
            strings_done = 0;
        endfunction

        function void emit(logic [7:0] b);
            t_dec_byte e;
            e.data = b;
            e.run_end = 1'b0;
            e.stream_end = 1'b0;
            group = {group, e};
        endfunction

        function void plain(logic [7:0] b, logic l);
            if (b == CH_PCT && !l) begin
                mode = MODE_PCT;
            end else if (b == CH_PLUS) begin
                emit(CH_SPACE);
            end else begin
                emit(b);
            end
        endfunction

        function void note_word(logic [7:0] b, logic l);
            int    lo;
            int    hi;
            t_mode was;
            lo = hex_nibble(b);
            was = mode;
            mode = MODE_IDLE;
            group.delete();
            words_in++;
            case (was)
                MODE_PCT: begin
                    if (lo >= 0 && !l) begin
                        held_digit = b;
                        mode = MODE_HEX1;
                    end else begin
                        emit(CH_PCT);
                        plain(b, l);
                    end
                end
                MODE_HEX1: begin
                    hi = hex_nibble(held_digit);
                    if (lo >= 0 && hi >= 0) begin
                        emit({hi[3:0], lo[3:0]});
                    end else begin
                        emit(CH_PCT);
                        emit(held_digit);
                        plain(b, l);
                    end
                end
                default: plain(b, l);
            endcase
            if (group.size() > 0) begin
                group[group.size()-1].run_end = 1'b1;
                if (l) begin
                    group[group.size()-1].stream_end = 1'b1;
                end
            end
            if (l) begin
                mode = MODE_IDLE;
                strings_done++;
            end
            pending_out = {pending_out, group};
        endfunction

        function void check_result(logic [7:0] b, logic re, logic se);
            t_dec_byte want;
            bytes_out++;
            if (pending_out.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected byte %02h run_end %b stream_end %b", b, re, se);
                end
                return;
            end
            want = pending_out.pop_front();
            if (want.data !== b || want.run_end !== re || want.stream_end !== se) begin
                errors++;
                if (errors <= 10) begin
                    $display("byte %0d: expected %02h run_end %b stream_end %b, got %02h %b %b",
                             bytes_out, want.data, want.run_end, want.stream_end, b, re, se);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_run_end;
    logic       o_stream_end;

    decode_scoreboard sb;
    bit idle_on = 1'b0;
    int stall_left = 0;
    int cycles = 0;

    url_percent_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end),
        .o_stream_end(o_stream_end)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("url_percent_decoder_unit: mismatch");
            $finish;
        end
    end

    // Result side: check every popped byte, and stall the pop in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_out_byte, o_run_end, o_stream_end);
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            pop <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 15);
            end
        end
    end

    // Holds push high until the word is taken; push only drops for a gap or at the end.
    task automatic drive_word(input logic [7:0] b, input logic l);
        push <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        do begin
            @(posedge i_clk);
        end while (full);
        sb.note_word(b, l);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) >= 0) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    initial begin
        logic [7:0] text[$];
        int         sent;
        int         pieces;
        sb = new();
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_in_byte <= 8'h00;
        i_in_last <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extreme bytes and a plus, then complete, broken and final-byte escapes.
        drive_word(8'h00, 1'b0);
        drive_word(8'hFF, 1'b0);
        drive_word(CH_PLUS, 1'b0);
        drive_word("A", 1'b1);
        drive_word(CH_PCT, 1'b0);
        drive_word("4", 1'b0);
        drive_word("1", 1'b1);
        drive_word(CH_PCT, 1'b0);
        drive_word("4", 1'b0);
        drive_word("g", 1'b0);
        drive_word(CH_PCT, 1'b0);
        drive_word(CH_PCT, 1'b0);
        drive_word("2", 1'b0);
        drive_word("B", 1'b1);
        drive_word(CH_PCT, 1'b1);
        drive_word(CH_PCT, 1'b0);
        drive_word(CH_PLUS, 1'b1);
        drive_word(CH_PCT, 1'b0);
        drive_word("a", 1'b0);
        drive_word(CH_PLUS, 1'b1);
        drive_word(CH_PCT, 1'b0);
        drive_word("f", 1'b0);
        drive_word("F", 1'b0);
        drive_word("z", 1'b1);
        drive_word(CH_PCT, 1'b0);
        drive_word("a", 1'b0);
        drive_word(CH_PCT, 1'b1);

        // Mostly well-formed strings built from escapes, plain bytes and broken
        // escapes, with some loose words of random content mixed in.
        sent = 0;
        idle_on = 1'b1;
        while (sent < RANDOM_WORDS) begin
            if (sent >= RANDOM_WORDS - 80) begin
                idle_on = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                idle_on = !idle_on;
            end
            text.delete();
            if ($urandom_range(0, 9) == 0) begin
                drive_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
                continue;
            end
            pieces = $urandom_range(1, 6);
            repeat (pieces) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: text = {text, 8'($urandom_range(0, 255))};
                    3: text = {text, CH_PLUS};
                    4, 5, 6: begin
                        text = {text, CH_PCT};
                        text = {text, rand_hex()};
                        text = {text, rand_hex()};
                    end
                    7: begin
                        text = {text, CH_PCT};
                        text = {text, rand_non_hex()};
                    end
                    8: begin
                        text = {text, CH_PCT};
                        text = {text, rand_hex()};
                        text = {text, rand_non_hex()};
                    end
                    default: begin
                        text = {text, CH_PCT};
                        if ($urandom_range(0, 1)) begin
                            text = {text, rand_hex()};
                        end
                    end
                endcase
            end
            foreach (text[i]) begin
                drive_word(text[i], i == text.size() - 1);
                sent++;
            end
        end
        push <= 1'b0;

        while (sb.pending_out.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (sb.pending_out.size() != 0) begin
            sb.errors++;
            $display("%0d expected bytes never arrived", sb.pending_out.size());
        end
        $display("Sent %0d words in %0d closed strings, with complete, broken and final escapes;",
                 sb.words_in, sb.strings_done);
        $display("popped %0d decoded bytes, %0d of them wrong or unexpected.",
                 sb.bytes_out, sb.errors);
        if (sb.errors == 0) begin
            $display("url_percent_decoder_unit: match");
        end else begin
            $display("url_percent_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
